// File: rtl/gait_servo_sequencer_defines.svh
// ----------------------------------------------------------------------------
// gait servo sequencer assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GAIT_SERVO_SEQUENCER_DEFINES_SVH
`define GAIT_SERVO_SEQUENCER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// types, codes and gait tables shared by the gait servo sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

	localparam int unsigned N_SERVO = 3;
	localparam logic [1:0] SERVO_FRONT  = 2'd0;
	localparam logic [1:0] SERVO_MIDDLE = 2'd1;
	localparam logic [1:0] SERVO_REAR   = 2'd2;

	// input item kinds
	localparam logic ITEM_TICK = 1'b0;
	localparam logic ITEM_CMD  = 1'b1;

	// configuration register indexes (byte address bit 2)
	localparam logic REG_PULSE_MIN = 1'b0;
	localparam logic REG_PULSE_MAX = 1'b1;
	localparam logic [7:0] PULSE_MIN_RST = 8'd8;
	localparam logic [7:0] PULSE_MAX_RST = 8'd38;

	// gait selections
	localparam logic [2:0] GAIT_NONE = 3'd0;
	localparam logic [2:0] GAIT_F    = 3'd1;
	localparam logic [2:0] GAIT_B    = 3'd2;
	localparam logic [2:0] GAIT_L    = 3'd3;
	localparam logic [2:0] GAIT_R    = 3'd4;
	localparam logic [2:0] GAIT_STOP = 3'd5;

	localparam logic [3:0] LEN_FB   = 4'd5;
	localparam logic [3:0] LEN_LR   = 4'd9;
	localparam logic [3:0] LEN_STOP = 4'd1;

	// command characters
	localparam logic [7:0] CMD_F = 8'h66;
	localparam logic [7:0] CMD_B = 8'h62;
	localparam logic [7:0] CMD_L = 8'h6c;
	localparam logic [7:0] CMD_R = 8'h72;

	// lamps
	localparam logic [4:0] LAMP_STICKY = 5'b10000;
	localparam logic [4:0] LAMP_STOP   = 5'b00001;
	localparam logic [4:0] LAMP_F      = 5'b00010;
	localparam logic [4:0] LAMP_B      = 5'b00100;
	localparam logic [4:0] LAMP_L      = 5'b01000;
	localparam logic [4:0] LAMP_R      = 5'b10000;

	// angles in degrees
	localparam logic [7:0] ANG_CENTER   = 8'd90;
	localparam logic [7:0] ANG_MID_HIGH = 8'd105;
	localparam logic [7:0] ANG_MID_LOW  = 8'd75;
	localparam logic [7:0] ANG_LEG_LOW  = 8'd60;
	localparam logic [7:0] ANG_LEG_HIGH = 8'd120;
	localparam logic [7:0] ANG_MAX      = 8'd180;

	// floor(x / 45) for x below 2**14, so floor(p / 180) = floor((p >> 2) / 45)
	localparam logic [13:0] RECIP_45    = 14'd11651;
	localparam int unsigned RECIP_SHIFT = 19;

	// step kinds
	localparam logic [3:0] KIND_CENTER      = 4'd0;
	localparam logic [3:0] KIND_MID_UP      = 4'd1;
	localparam logic [3:0] KIND_LEGS_FWD    = 4'd2;
	localparam logic [3:0] KIND_MID_DOWN    = 4'd3;
	localparam logic [3:0] KIND_LEGS_BACK   = 4'd4;
	localparam logic [3:0] KIND_MID_SETTLE  = 4'd5;
	localparam logic [3:0] KIND_BACK_SETTLE = 4'd6;
	localparam logic [3:0] KIND_MID_RISE    = 4'd7;
	localparam logic [3:0] KIND_FWD_SETTLE  = 4'd8;
	localparam logic [3:0] KIND_SKIP        = 4'd9;

	localparam logic [3:0] SEQ_SLOTS = 4'd9;

	// gait rows, slot 0 in the low nibble
	localparam logic [35:0] SEQ_HOLD = {9{KIND_CENTER}};
	localparam logic [35:0] SEQ_F = {KIND_CENTER, KIND_CENTER, KIND_CENTER, KIND_CENTER,
		KIND_LEGS_BACK, KIND_MID_DOWN, KIND_LEGS_FWD, KIND_MID_UP, KIND_CENTER};
	localparam logic [35:0] SEQ_B = {KIND_CENTER, KIND_CENTER, KIND_CENTER, KIND_CENTER,
		KIND_LEGS_BACK, KIND_MID_UP, KIND_LEGS_FWD, KIND_MID_DOWN, KIND_CENTER};
	localparam logic [35:0] SEQ_L = {KIND_FWD_SETTLE, KIND_MID_RISE, KIND_LEGS_FWD,
		KIND_MID_UP, KIND_LEGS_BACK, KIND_MID_DOWN, KIND_LEGS_FWD, KIND_MID_UP,
		KIND_CENTER};
	localparam logic [35:0] SEQ_R = {KIND_BACK_SETTLE, KIND_MID_SETTLE, KIND_LEGS_BACK,
		KIND_MID_DOWN, KIND_LEGS_FWD, KIND_MID_UP, KIND_LEGS_BACK, KIND_MID_DOWN,
		KIND_CENTER};

	typedef struct packed {
		logic       kind;
		logic [7:0] command_byte;
	} gss_in_t;

	typedef struct packed {
		logic [7:0] front_compare;
		logic [7:0] middle_compare;
		logic [7:0] rear_compare;
		logic [4:0] led_pattern;
		logic [3:0] sequence_index;
	} gss_out_t;

	typedef struct packed {
		logic [7:0] front_angle;
		logic [7:0] middle_angle;
		logic [7:0] rear_angle;
		logic [3:0] index;
		logic [2:0] gait;
		logic [3:0] gait_len;
		logic [4:0] lamp;
		logic [7:0] last_command;
	} gss_state_t;

	typedef logic [N_SERVO-1:0][7:0] angle_vec_t;

	function automatic logic [3:0] seq_kind(input logic [2:0] gait, input logic [3:0] idx);
		logic [35:0] row;
		unique case (gait)
			GAIT_F:  row = SEQ_F;
			GAIT_B:  row = SEQ_B;
			GAIT_L:  row = SEQ_L;
			GAIT_R:  row = SEQ_R;
			default: row = SEQ_HOLD;
		endcase
		if (idx < SEQ_SLOTS) begin
			seq_kind = row[{idx, 2'b00} +: 4];
		end else begin
			seq_kind = KIND_SKIP;
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/gss_step.sv
// ----------------------------------------------------------------------------
// gss_step
// next sequencer state for one tick or one command byte
// ----------------------------------------------------------------------------
`default_nettype none

module gss_step
	import gss_pkg::*;
(
	input  gss_state_t state,
	input  gss_in_t    item,
	output gss_state_t state_next
);

	logic [3:0] idx;
	logic [3:0] kind_code;
	logic       adv;
	logic [7:0] front;
	logic [7:0] middle;
	logic [7:0] rear;
	logic [4:0] lamp;

	always_comb begin
		state_next = state;
		idx        = state.index;
		kind_code  = KIND_SKIP;
		adv        = 1'b0;
		front      = state.front_angle;
		middle     = state.middle_angle;
		rear       = state.rear_angle;
		lamp       = state.lamp;

		if (item.kind == ITEM_CMD) begin
			if (item.command_byte != state.last_command) begin
				state_next.last_command = item.command_byte;
				state_next.index        = '0;
				lamp = state.lamp & LAMP_STICKY;
				unique case (item.command_byte)
					CMD_F: begin
						state_next.gait     = GAIT_F;
						state_next.gait_len = LEN_FB;
						lamp = lamp | LAMP_F;
					end
					CMD_B: begin
						state_next.gait     = GAIT_B;
						state_next.gait_len = LEN_FB;
						lamp = lamp | LAMP_B;
					end
					CMD_L: begin
						state_next.gait     = GAIT_L;
						state_next.gait_len = LEN_LR;
						lamp = lamp | LAMP_L;
					end
					CMD_R: begin
						state_next.gait     = GAIT_R;
						state_next.gait_len = LEN_LR;
						lamp = lamp | LAMP_R;
					end
					default: begin
						state_next.gait     = GAIT_STOP;
						state_next.gait_len = LEN_STOP;
						lamp = lamp | LAMP_STOP;
					end
				endcase
				state_next.lamp = lamp;
			end
		end else begin
			// rewind once the index runs past the gait
			if (({1'b0, state.index} + 5'd1) > {1'b0, state.gait_len}) begin
				idx = 4'd1;
			end
			kind_code = seq_kind(state.gait, idx);
			unique case (kind_code)
				KIND_CENTER: begin
					front  = ANG_CENTER;
					middle = ANG_CENTER;
					rear   = ANG_CENTER;
					lamp   = state.lamp & LAMP_STICKY;
					adv    = 1'b1;
				end
				KIND_MID_UP: begin
					middle = state.middle_angle + 8'd1;
					adv    = middle >= ANG_MID_HIGH;
					lamp   = state.lamp | LAMP_F;
				end
				KIND_LEGS_FWD: begin
					front = state.front_angle + 8'd1;
					rear  = state.rear_angle - 8'd1;
					adv   = (rear <= ANG_LEG_LOW) && (front >= ANG_LEG_HIGH);
				end
				KIND_MID_DOWN: begin
					lamp   = state.lamp & LAMP_STICKY;
					middle = state.middle_angle - 8'd1;
					adv    = middle <= ANG_MID_LOW;
				end
				KIND_LEGS_BACK: begin
					front = state.front_angle - 8'd1;
					rear  = state.rear_angle + 8'd1;
					adv   = (front <= ANG_LEG_LOW) && (rear >= ANG_LEG_HIGH);
				end
				KIND_MID_SETTLE: begin
					middle = state.middle_angle - 8'd1;
					adv    = middle <= ANG_CENTER;
				end
				KIND_BACK_SETTLE: begin
					front = state.front_angle - 8'd1;
					rear  = state.rear_angle + 8'd1;
					adv   = (front <= ANG_CENTER) && (rear >= ANG_CENTER);
				end
				KIND_MID_RISE: begin
					middle = state.middle_angle + 8'd1;
					adv    = middle >= ANG_CENTER;
				end
				KIND_FWD_SETTLE: begin
					front = state.front_angle + 8'd1;
					rear  = state.rear_angle - 8'd1;
					adv   = (front >= ANG_CENTER) && (rear <= ANG_CENTER);
				end
				default: begin
					adv = 1'b1;
				end
			endcase
			state_next.front_angle  = front;
			state_next.middle_angle = middle;
			state_next.rear_angle   = rear;
			state_next.lamp         = lamp;
			state_next.index        = adv ? (idx + 4'd1) : idx;
		end
	end

endmodule

`default_nettype wire

// File: rtl/gss_scale.sv
// ----------------------------------------------------------------------------
// gss_scale
// angle to pulse compare conversion, two register stages
// ----------------------------------------------------------------------------
`default_nettype none

`include "gait_servo_sequencer_defines.svh"

module gss_scale
	import gss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_s2,
	input  logic       valid_s3,
	input  logic       tick_s2,
	input  angle_vec_t angles_s2,
	input  logic [7:0] pulse_min,
	input  logic [7:0] pulse_max,
	output angle_vec_t compare
);

	logic [7:0]  lo;
	logic [7:0]  hi;
	logic [7:0]  span;
	logic [15:0] prod_s3   [N_SERVO];
	logic        inrange_s3 [N_SERVO];
	logic [27:0] recip     [N_SERVO];
	logic [7:0]  compare_q [N_SERVO];

	assign lo   = pulse_min;
	assign hi   = (pulse_max < pulse_min) ? pulse_min : pulse_max;
	assign span = hi - lo;

	for (genvar i = 0; i < N_SERVO; i++) begin : g_servo
		// compares only move on a gait tick, never on a command byte
		always_ff @(posedge clk) begin
			if (en && valid_s2) begin
				prod_s3[i]    <= {8'd0, angles_s2[i]} * {8'd0, span};
				inrange_s3[i] <= tick_s2 && (angles_s2[i] <= ANG_MAX);
			end
		end

		// divide by 180: drop two bits, then multiply by the reciprocal of 45
		assign recip[i] = {14'd0, prod_s3[i][15:2]} * {14'd0, RECIP_45};

		// an angle past full scale keeps the previous compare value
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				compare_q[i] <= '0;
			end else if (en && valid_s3 && inrange_s3[i]) begin
				compare_q[i] <= recip[i][RECIP_SHIFT +: 8] + lo;
			end
		end

		assign compare[i] = compare_q[i];
	end

	`GSS_ASSERT_NEXT(a_front_hold, en && valid_s3 && !inrange_s3[SERVO_FRONT], $stable(compare_q[SERVO_FRONT]), "front compare changed for an out of range angle")

endmodule

`default_nettype wire

// File: rtl/gait_servo_sequencer.sv
// ----------------------------------------------------------------------------
// gait_servo_sequencer
// three-servo gait sequencer with pulse compare outputs
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one item per transaction:
// a gait tick or a command byte. Every accepted item yields exactly one
// result transaction on out_valid/out_stall/out_data carrying the three
// servo compare values, the lamp pattern and the sequence index.
// One item per cycle is sustained while out_stall does not hold the pipe;
// the sequencer state is computed from the input register and registered,
// and the angle-to-compare scaling takes two more stages (the span
// multiply, then the reciprocal multiply for the divide by 180).
// While out_valid is high and out_stall is held, the whole pipe freezes and
// in_stall is raised; the result stays on out_data.
// Reset puts the angles at 0/90/180, no gait selected, lamps and compares
// cleared, pulse_min 8 and pulse_max 38. The APB registers are at byte
// address 0 (pulse_min) and 4 (pulse_max); pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gait_servo_sequencer_defines.svh"

module gait_servo_sequencer
	import gss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  gss_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output gss_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       en;
	logic       cfg_wr;
	logic [7:0] pulse_min_q;
	logic [7:0] pulse_max_q;

	logic       valid_s1;
	gss_in_t    item_s1;
	gss_state_t state_q;
	gss_state_t state_d;

	logic       valid_s2;
	logic       tick_s2;
	angle_vec_t angles_s2;
	logic [4:0] lamp_s2;
	logic [3:0] index_s2;

	logic       valid_s3;
	logic [4:0] lamp_s3;
	logic [3:0] index_s3;

	logic       out_valid_q;
	logic [4:0] lamp_q;
	logic [3:0] index_q;
	angle_vec_t compare;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= PULSE_MIN_RST;
			pulse_max_q <= PULSE_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PULSE_MIN: pulse_min_q <= pwdata[7:0];
				REG_PULSE_MAX: pulse_max_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PULSE_MIN: prdata = {24'd0, pulse_min_q};
			REG_PULSE_MAX: prdata = {24'd0, pulse_max_q};
			default:       prdata = '0;
		endcase
	end

	// whole pipe moves unless a finished result is being held
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			item_s1 <= in_data;
		end
	end

	gss_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.front_angle  <= 8'd0;
			state_q.middle_angle <= ANG_CENTER;
			state_q.rear_angle   <= ANG_MAX;
			state_q.index        <= '0;
			state_q.gait         <= GAIT_NONE;
			state_q.gait_len     <= '0;
			state_q.lamp         <= '0;
			state_q.last_command <= '0;
		end else if (en && valid_s1) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			tick_s2                 <= (item_s1.kind == ITEM_TICK);
			angles_s2[SERVO_FRONT]  <= state_d.front_angle;
			angles_s2[SERVO_MIDDLE] <= state_d.middle_angle;
			angles_s2[SERVO_REAR]   <= state_d.rear_angle;
			lamp_s2                 <= state_d.lamp;
			index_s2                <= state_d.index;
		end
		if (en && valid_s2) begin
			lamp_s3  <= lamp_s2;
			index_s3 <= index_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q  <= '0;
			index_q <= '0;
		end else if (en && valid_s3) begin
			lamp_q  <= lamp_s3;
			index_q <= index_s3;
		end
	end

	gss_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s2  (valid_s2),
		.valid_s3  (valid_s3),
		.tick_s2   (tick_s2),
		.angles_s2 (angles_s2),
		.pulse_min (pulse_min_q),
		.pulse_max (pulse_max_q),
		.compare   (compare)
	);

	assign out_valid               = out_valid_q;
	assign out_data.front_compare  = compare[SERVO_FRONT];
	assign out_data.middle_compare = compare[SERVO_MIDDLE];
	assign out_data.rear_compare   = compare[SERVO_REAR];
	assign out_data.led_pattern    = lamp_q;
	assign out_data.sequence_index = index_q;

	`GSS_ASSERT_NEXT(a_s1_to_s2, en && valid_s1, valid_s2, "item lost between input register and stage 2")
	`GSS_ASSERT_NEXT(a_s3_to_out, en && valid_s3, out_valid_q, "item lost before result register")
	`GSS_ASSERT_SAME(a_lamp_sticky, 1'b1, !$fell(state_q.lamp[4]), "sticky lamp was cleared")
	`GSS_ASSERT_NEXT(a_cmd_index, en && valid_s1 && item_s1.kind == ITEM_CMD && item_s1.command_byte != state_q.last_command, state_q.index == '0, "new command did not rewind index")

endmodule

`default_nettype wire
